// ----- rtl/coverage_longest_run_finder_core_defines.svh -----
// Assertion macros for the file that carries concurrent checks.
// Each macro expects signals named clk and arst_n in the using scope.
`ifndef COVERAGE_LONGEST_RUN_FINDER_CORE_DEFINES_SVH
`define COVERAGE_LONGEST_RUN_FINDER_CORE_DEFINES_SVH

// The consequent must hold in the cycle after the antecedent.
`define CLRF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define CLRF_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ----- rtl/clrf_pkg.sv -----
`timescale 1ns / 1ps

package clrf_pkg;

	localparam int POS_W      = 17;
	localparam int MARGIN_W   = 15;
	localparam int MIND_W     = 16;
	localparam int CFG_DATA_W = 17;
	localparam int CFG_IDX_W  = 2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_LENGTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TRIM_MARGIN   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_DEPTH     = 2'd2;

	localparam logic [MIND_W-1:0] MIN_DEPTH_RST = 16'd1;

	// Item actions.
	localparam logic ACT_ADD    = 1'b0;
	localparam logic ACT_FINISH = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ADD_INC,
		ST_ADD_DEC,
		ST_WALK,
		ST_DRAIN1,
		ST_DRAIN2,
		ST_FINAL
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic add_accept;
		logic fin_accept;
		logic inc_wr;
		logic dec_wr;
		logic clr_wr;
		logic walk_rd;
		logic final_step;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic keep;
		logic clr_last;
		logic walk_last;
	} status_t;

endpackage

// ----- rtl/clrf_ram.sv -----
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one read port, registered read data.
// A read of the address being written returns the old contents.
module clrf_ram #(
	parameter int WIDTH = 17,
	parameter int DEPTH = 65537,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/clrf_cfg.sv -----
`timescale 1ns / 1ps

// Configuration registers and the effective target length.
module clrf_cfg #(
	parameter int MAX_LENGTH = 65536,
	localparam int AW = $clog2(MAX_LENGTH + 1)
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [clrf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [clrf_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	output logic [AW-1:0]                    eff_len,
	output logic [clrf_pkg::MARGIN_W-1:0]    trim_margin,
	output logic [clrf_pkg::MIND_W-1:0]      min_depth
);

	localparam int LW = (AW > clrf_pkg::POS_W) ? AW : clrf_pkg::POS_W;
	localparam logic [LW-1:0] MAX_L = LW'(MAX_LENGTH);

	logic [clrf_pkg::POS_W-1:0]  target_q;
	logic [clrf_pkg::MARGIN_W-1:0] margin_q;
	logic [clrf_pkg::MIND_W-1:0]   min_q;
	logic [LW-1:0]                 tgt_ext;
	logic [LW-1:0]                 eff_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
			margin_q <= '0;
			min_q    <= clrf_pkg::MIN_DEPTH_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				clrf_pkg::REG_TARGET_LENGTH: target_q <= cfg_wdata[clrf_pkg::POS_W-1:0];
				clrf_pkg::REG_TRIM_MARGIN:   margin_q <= cfg_wdata[clrf_pkg::MARGIN_W-1:0];
				clrf_pkg::REG_MIN_DEPTH:     min_q    <= cfg_wdata[clrf_pkg::MIND_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// The target is clipped to MAX_LENGTH.
	always_comb begin
		tgt_ext = LW'(target_q);
		eff_ext = (tgt_ext >= MAX_L) ? MAX_L : tgt_ext;
	end

	assign eff_len     = AW'(eff_ext);
	assign trim_margin = margin_q;
	assign min_depth   = min_q;

endmodule

// ----- rtl/clrf_ctrl.sv -----
`timescale 1ns / 1ps

// Sequencer for the clearing pass, interval updates and the finish walk.
module clrf_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               action,
	input  clrf_pkg::status_t  status,
	output logic               busy,
	output clrf_pkg::cmd_t     cmd
);

	clrf_pkg::state_t state_q;
	clrf_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= clrf_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			clrf_pkg::ST_CLEAR: begin
				if (status.clr_last) begin
					state_d = clrf_pkg::ST_IDLE;
				end
			end
			clrf_pkg::ST_IDLE: begin
				if (start) begin
					if (action == clrf_pkg::ACT_FINISH) begin
						state_d = clrf_pkg::ST_WALK;
					end else if (status.keep) begin
						state_d = clrf_pkg::ST_ADD_INC;
					end
				end
			end
			clrf_pkg::ST_ADD_INC: state_d = clrf_pkg::ST_ADD_DEC;
			clrf_pkg::ST_ADD_DEC: state_d = clrf_pkg::ST_IDLE;
			clrf_pkg::ST_WALK: begin
				if (status.walk_last) begin
					state_d = clrf_pkg::ST_DRAIN1;
				end
			end
			clrf_pkg::ST_DRAIN1: state_d = clrf_pkg::ST_DRAIN2;
			clrf_pkg::ST_DRAIN2: state_d = clrf_pkg::ST_FINAL;
			clrf_pkg::ST_FINAL:  state_d = clrf_pkg::ST_IDLE;
		endcase
	end

	assign busy = (state_q != clrf_pkg::ST_IDLE);

	always_comb begin
		cmd = '0;
		unique case (state_q)
			clrf_pkg::ST_CLEAR: cmd.clr_wr = 1'b1;
			clrf_pkg::ST_IDLE: begin
				cmd.add_accept = start && (action == clrf_pkg::ACT_ADD);
				cmd.fin_accept = start && (action == clrf_pkg::ACT_FINISH);
			end
			clrf_pkg::ST_ADD_INC: cmd.inc_wr = 1'b1;
			clrf_pkg::ST_ADD_DEC: cmd.dec_wr = 1'b1;
			clrf_pkg::ST_WALK:    cmd.walk_rd = 1'b1;
			clrf_pkg::ST_DRAIN1, clrf_pkg::ST_DRAIN2: cmd = '0;
			clrf_pkg::ST_FINAL:   cmd.final_step = 1'b1;
		endcase
	end

endmodule

// ----- rtl/clrf_dpath.sv -----
`timescale 1ns / 1ps

// Difference store, saturating updates, prefix-sum walk and run tracking.
module clrf_dpath #(
	parameter int MAX_LENGTH = 65536,
	parameter int DEPTH_BITS = 16,
	localparam int AW = $clog2(MAX_LENGTH + 1)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  clrf_pkg::cmd_t                 cmd,
	output clrf_pkg::status_t              status,
	input  logic [clrf_pkg::POS_W-1:0]     interval_start,
	input  logic [clrf_pkg::POS_W-1:0]     interval_end,
	input  logic [AW-1:0]                  eff_len,
	input  logic [clrf_pkg::MARGIN_W-1:0]  trim_margin,
	input  logic [clrf_pkg::MIND_W-1:0]    min_depth,
	output logic                           done,
	output logic [clrf_pkg::POS_W-1:0]     run_start,
	output logic [clrf_pkg::POS_W-1:0]     run_end
);

	localparam int PW = clrf_pkg::POS_W;
	localparam int DW = DEPTH_BITS + 1;
	localparam int LW = (AW > PW) ? AW : PW;
	localparam int RW = LW + 1;
	localparam int QW = (DEPTH_BITS > clrf_pkg::MIND_W) ? DEPTH_BITS : clrf_pkg::MIND_W;
	localparam logic [DW-1:0] DELTA_MAX = DW'((64'd1 << DEPTH_BITS) - 64'd1);
	localparam logic [DW-1:0] DELTA_MIN = ~DELTA_MAX + DW'(1);
	localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_LENGTH);

	logic [PW-1:0]           a_in;
	logic [PW-1:0]           b_in;
	logic [PW-1:0]           span;
	logic                    keep_in;
	logic [AW-1:0]           a_q;
	logic [AW-1:0]           b_q;
	logic [AW-1:0]           hw_q;
	logic [AW-1:0]           end_q;
	logic [AW-1:0]           walk_q;
	logic [AW-1:0]           raddr;
	logic [AW-1:0]           waddr;
	logic                    we;
	logic [DW-1:0]           wdata;
	logic [DW-1:0]           rdata;
	logic [DW-1:0]           inc_val;
	logic [DW-1:0]           dec_val;
	logic                    valid_s1;
	logic                    valid_s2;
	logic [AW-1:0]           pos_s1;
	logic [AW-1:0]           pos_s2;
	logic [DEPTH_BITS+1:0]   sum;
	logic [DEPTH_BITS-1:0]   depth_nx;
	logic [DEPTH_BITS-1:0]   depth_s2;
	logic                    qual;
	logic                    in_run_q;
	logic                    found_q;
	logic                    seen_q;
	logic [RW-1:0]           cur_s_q;
	logic [RW-1:0]           best_s_q;
	logic [RW-1:0]           best_e_q;
	logic [RW-1:0]           best_len_q;
	logic [RW-1:0]           run_len;
	logic [RW-1:0]           len_plus;
	logic [RW-1:0]           tail_len;
	logic                    take_tail;
	logic                    done_q;
	logic [PW-1:0]           run_start_q;
	logic [PW-1:0]           run_end_q;

	// Trimmed interval and its acceptance test.
	always_comb begin
		a_in    = interval_start + PW'(trim_margin);
		b_in    = interval_end - PW'(trim_margin);
		span    = interval_end - interval_start;
		keep_in = (LW'(interval_end) <= LW'(eff_len)) &&
		          (interval_end > interval_start) &&
		          (span > PW'({trim_margin, 1'b0}));
	end

	assign status.keep      = keep_in;
	assign status.clr_last  = (walk_q == LAST_ADDR);
	assign status.walk_last = (walk_q == end_q);

	// Saturating delta updates.
	assign inc_val = (rdata == DELTA_MAX) ? rdata : rdata + DW'(1);
	assign dec_val = (rdata == DELTA_MIN) ? rdata : rdata - DW'(1);

	always_comb begin
		priority if (cmd.inc_wr) begin
			raddr = b_q;
		end else if (cmd.walk_rd) begin
			raddr = walk_q;
		end else begin
			raddr = AW'(a_in);
		end
	end

	always_comb begin
		we = cmd.inc_wr | cmd.dec_wr | cmd.clr_wr | cmd.walk_rd;
		priority if (cmd.inc_wr) begin
			waddr = a_q;
			wdata = inc_val;
		end else if (cmd.dec_wr) begin
			waddr = b_q;
			wdata = dec_val;
		end else begin
			waddr = walk_q;
			wdata = '0;
		end
	end

	clrf_ram #(
		.WIDTH(DW),
		.DEPTH(MAX_LENGTH + 1)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	// Running depth clamped to zero and the depth ceiling.
	always_comb begin
		sum = {2'b00, depth_s2} + {rdata[DW-1], rdata};
		priority if (sum[DEPTH_BITS+1]) begin
			depth_nx = '0;
		end else if (sum[DEPTH_BITS]) begin
			depth_nx = '1;
		end else begin
			depth_nx = sum[DEPTH_BITS-1:0];
		end
	end

	always_comb begin
		qual      = (QW'(depth_s2) >= QW'(min_depth));
		run_len   = RW'(pos_s2) - cur_s_q;
		len_plus  = RW'(eff_len) + RW'(1);
		tail_len  = len_plus - cur_s_q;
		take_tail = in_run_q && (!found_q || (tail_len > best_len_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_q   <= '0;
			hw_q     <= '0;
			seen_q   <= 1'b0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			in_run_q <= 1'b0;
			found_q  <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			if (cmd.clr_wr) begin
				walk_q <= status.clr_last ? '0 : walk_q + AW'(1);
			end else if (cmd.walk_rd) begin
				walk_q <= status.walk_last ? '0 : walk_q + AW'(1);
			end

			if (cmd.fin_accept) begin
				hw_q <= '0;
			end else if (cmd.dec_wr && (b_q > hw_q)) begin
				hw_q <= b_q;
			end

			if (cmd.add_accept) begin
				seen_q <= 1'b1;
			end else if (cmd.final_step) begin
				seen_q <= 1'b0;
			end

			// Positions past the effective length are only cleared.
			valid_s1 <= cmd.walk_rd && (walk_q <= eff_len);
			valid_s2 <= valid_s1;
			done_q   <= cmd.final_step;

			if (cmd.fin_accept) begin
				in_run_q <= 1'b0;
				found_q  <= 1'b0;
			end else if (valid_s2) begin
				if (in_run_q) begin
					if (!qual) begin
						in_run_q <= 1'b0;
						found_q  <= 1'b1;
					end
				end else if (qual) begin
					in_run_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.add_accept) begin
			a_q <= AW'(a_in);
			b_q <= AW'(b_in);
		end

		if (cmd.fin_accept) begin
			end_q    <= (hw_q > eff_len) ? hw_q : eff_len;
			depth_s2 <= '0;
		end else if (valid_s1) begin
			depth_s2 <= depth_nx;
		end

		pos_s1 <= walk_q;
		pos_s2 <= pos_s1;

		if (valid_s2) begin
			if (in_run_q) begin
				if (!qual && (!found_q || (run_len > best_len_q))) begin
					best_s_q   <= cur_s_q;
					best_e_q   <= RW'(pos_s2);
					best_len_q <= run_len;
				end
			end else if (qual) begin
				cur_s_q <= RW'(pos_s2);
			end
		end

		if (cmd.final_step) begin
			if (seen_q && (found_q || in_run_q)) begin
				if (take_tail) begin
					run_start_q <= cur_s_q[PW-1:0];
					run_end_q   <= len_plus[PW-1:0];
				end else begin
					run_start_q <= best_s_q[PW-1:0];
					run_end_q   <= best_e_q[PW-1:0];
				end
			end else begin
				run_start_q <= '0;
				run_end_q   <= '0;
			end
		end
	end

	assign done      = done_q;
	assign run_start = run_start_q;
	assign run_end   = run_end_q;

endmodule

// ----- rtl/coverage_longest_run_finder_core.sv -----
// Longest well-covered run finder. An item is taken when start is high and busy
// is low; action 0 adds an interval, action 1 finishes and reports. The result
// appears on run_start and run_end for exactly one cycle with done high and
// cannot be held off, so the receiver must capture it in that cycle. An added
// interval occupies the block for the accept plus a read-modify-write of each
// end in the single difference memory, or only for the accept when it is
// dropped by the range and trim tests. A finish walks the memory one address
// per cycle from 0 up to the larger of the effective length and the highest
// address written since the previous finish, clearing each entry as it reads
// it; done is registered from state FINAL, which follows WALK, DRAIN1, DRAIN2.
// After reset the block clears all MAX_LENGTH + 1 memory entries, one per
// cycle, and holds busy high until that clearing pass ends; configuration
// writes are taken throughout.
`timescale 1ns / 1ps
`include "coverage_longest_run_finder_core_defines.svh"

module coverage_longest_run_finder_core #(
	parameter int MAX_LENGTH = 65536,
	parameter int DEPTH_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// Item command port.
	input  logic                             start,
	output logic                             busy,
	input  logic                             action,
	input  logic [clrf_pkg::POS_W-1:0]       interval_start,
	input  logic [clrf_pkg::POS_W-1:0]       interval_end,
	// Result port: valid for the single cycle in which done is high.
	output logic                             done,
	output logic [clrf_pkg::POS_W-1:0]       run_start,
	output logic [clrf_pkg::POS_W-1:0]       run_end,
	// Configuration write port.
	input  logic                             cfg_we,
	input  logic [clrf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [clrf_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

	localparam int AW = $clog2(MAX_LENGTH + 1);

	logic [AW-1:0]                   eff_len;
	logic [clrf_pkg::MARGIN_W-1:0]   trim_margin;
	logic [clrf_pkg::MIND_W-1:0]     min_depth;
	clrf_pkg::cmd_t                  cmd;
	clrf_pkg::status_t               status;

	// Configuration registers. The effective length is the target length
	// clipped to MAX_LENGTH.
	clrf_cfg #(
		.MAX_LENGTH(MAX_LENGTH)
	) u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.eff_len    (eff_len),
		.trim_margin(trim_margin),
		.min_depth  (min_depth)
	);

	// The controller sequences the clearing pass after reset, the two memory
	// updates of an added interval, and the finish walk with its drain.
	clrf_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.action(action),
		.status(status),
		.busy  (busy),
		.cmd   (cmd)
	);

	// The datapath holds the difference memory, computes the running depth as
	// the walk goes and keeps the current and best runs. Ties keep the earlier
	// run because a later one must be strictly longer to replace it.
	clrf_dpath #(
		.MAX_LENGTH(MAX_LENGTH),
		.DEPTH_BITS(DEPTH_BITS)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.interval_start(interval_start),
		.interval_end  (interval_end),
		.eff_len       (eff_len),
		.trim_margin   (trim_margin),
		.min_depth     (min_depth),
		.done          (done),
		.run_start     (run_start),
		.run_end       (run_end)
	);

	// The result strobe lasts one cycle, follows a busy period, and a finish
	// item always takes the block busy.
	`CLRF_ASSERT_NEXT(a_done_pulse, done, !done, "result strobe held for more than one cycle")
	`CLRF_ASSERT_NOW(a_done_after_busy, done, $past(busy), "result without a finish in progress")
	`CLRF_ASSERT_NEXT(a_finish_busy, start && !busy && action == clrf_pkg::ACT_FINISH, busy, "finish item did not start the walk")

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps

typedef struct packed {
	logic [16:0] first;
	logic [16:0] stop;
} covered_run_t;

// Tracks the coverage deltas as the block should hold them and keeps the
// queue of runs that finish items are expected to report.
class run_checker;
	localparam int MAX_LEN   = 65536;
	localparam int DEPTH_MAX = (1 << 16) - 1;

	int           coverage_steps[MAX_LEN + 1];
	int           top_marked;
	bit           interval_seen;
	logic [16:0]  length_reg;
	logic [14:0]  margin_reg;
	logic [15:0]  min_depth_reg;
	covered_run_t expected_runs[$];
	int           errors;

	function new();
		length_reg    = '0;
		margin_reg    = '0;
		min_depth_reg = clrf_pkg::MIN_DEPTH_RST;
		interval_seen = 1'b0;
		top_marked    = 0;
		errors        = 0;
		foreach (coverage_steps[i])
			coverage_steps[i] = 0;
	endfunction

	function void write_reg(logic [clrf_pkg::CFG_IDX_W-1:0] idx,
			logic [clrf_pkg::CFG_DATA_W-1:0] data);
		case (idx)
			clrf_pkg::REG_TARGET_LENGTH: length_reg    = data[16:0];
			clrf_pkg::REG_TRIM_MARGIN:   margin_reg    = data[14:0];
			clrf_pkg::REG_MIN_DEPTH:     min_depth_reg = data[15:0];
			default: ;
		endcase
	endfunction

	function int clamp(int v, int lo, int hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	function int covered_length();
		return (int'(length_reg) < MAX_LEN) ? int'(length_reg) : MAX_LEN;
	endfunction

	function void mark_interval(logic [16:0] s, logic [16:0] e);
		int len;
		int lo;
		int hi;
		len = covered_length();
		interval_seen = 1'b1;
		if (int'(e) > len || e <= s)
			return;
		if (int'(e) - int'(s) <= 2 * int'(margin_reg))
			return;
		lo = int'(s) + int'(margin_reg);
		hi = int'(e) - int'(margin_reg);
		coverage_steps[lo] = clamp(coverage_steps[lo] + 1, -DEPTH_MAX, DEPTH_MAX);
		coverage_steps[hi] = clamp(coverage_steps[hi] - 1, -DEPTH_MAX, DEPTH_MAX);
		if (hi > top_marked)
			top_marked = hi;
	endfunction

	// Prefix-sums the deltas over 0..L, keeps the longest (earliest on a tie)
	// run at or above the minimum depth, and empties the store.
	function covered_run_t longest_run();
		covered_run_t best;
		int len;
		int depth;
		int run_from;
		int best_s;
		int best_e;
		int sweep_top;
		bit found;
		bit in_run;
		len      = covered_length();
		depth    = 0;
		run_from = 0;
		best_s   = 0;
		best_e   = 0;
		found    = 1'b0;
		in_run   = 1'b0;
		for (int i = 0; i <= len; i++) begin
			depth = clamp(depth + coverage_steps[i], 0, DEPTH_MAX);
			if (in_run) begin
				if (depth < int'(min_depth_reg)) begin
					if (!found || i - run_from > best_e - best_s) begin
						best_s = run_from;
						best_e = i;
						found  = 1'b1;
					end
					in_run = 1'b0;
				end
			end else if (depth >= int'(min_depth_reg)) begin
				run_from = i;
				in_run   = 1'b1;
			end
		end
		if (in_run && (!found || len + 1 - run_from > best_e - best_s)) begin
			best_s = run_from;
			best_e = len + 1;
			found  = 1'b1;
		end
		if (!interval_seen || !found) begin
			best_s = 0;
			best_e = 0;
		end
		best.first = best_s[16:0];
		best.stop  = best_e[16:0];
		sweep_top = (top_marked > len) ? top_marked : len;
		for (int i = 0; i <= sweep_top; i++)
			coverage_steps[i] = 0;
		top_marked    = 0;
		interval_seen = 1'b0;
		return best;
	endfunction

	function void take_item(logic act, logic [16:0] s, logic [16:0] e);
		if (act == clrf_pkg::ACT_ADD)
			mark_interval(s, e);
		else
			expected_runs.insert(expected_runs.size(), longest_run());
	endfunction

	function void check_run(logic [16:0] rs, logic [16:0] re);
		covered_run_t want;
		if (expected_runs.size() == 0) begin
			$display("%0t: unexpected run: expected none, actual start %0d end %0d",
				$time, rs, re);
			errors++;
			return;
		end
		want = expected_runs.pop_front();
		if (rs !== want.first) begin
			$display("%0t: run_start mismatch: expected %0d, actual %0d",
				$time, want.first, rs);
			errors++;
		end
		if (re !== want.stop) begin
			$display("%0t: run_end mismatch: expected %0d, actual %0d",
				$time, want.stop, re);
			errors++;
		end
	endfunction
endclass

module tb_top;
	import clrf_pkg::*;

	localparam int MAX_LENGTH  = 65536;
	localparam int DEPTH_BITS  = 16;
	localparam int CYCLE_LIMIT = 3_000_000;
	localparam int ITEM_GOAL   = 1625;

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	logic                  action;
	logic [POS_W-1:0]      interval_start;
	logic [POS_W-1:0]      interval_end;
	logic                  done;
	logic [POS_W-1:0]      run_start;
	logic [POS_W-1:0]      run_end;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	run_checker runs;
	int         items_sent;
	int         cycle_count;
	int         big_phases;
	// When set, the sender presents items back to back with no idle cycles.
	bit         burst;

	coverage_longest_run_finder_core #(
		.MAX_LENGTH(MAX_LENGTH),
		.DEPTH_BITS(DEPTH_BITS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.action(action),
		.interval_start(interval_start),
		.interval_end(interval_end),
		.done(done),
		.run_start(run_start),
		.run_end(run_end),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// The block cannot stall its result, so every cycle with done high is
	// checked against the oldest expected run.
	always @(posedge clk) begin
		if (arst_n && done)
			runs.check_run(run_start, run_end);
	end

	// Watchdog. The slowest legal run is the reset clear pass plus a handful of
	// full-length walks plus the small items, well below this limit.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	// Presents one item after a random idle gap and holds it until the block
	// takes it. Start is left high on return; the next task call lowers it or
	// reuses it at the very next falling edge, so an item is never taken twice
	// and start never sees two assignments in one step.
	task automatic send_item(input logic act, input logic [POS_W-1:0] s,
			input logic [POS_W-1:0] e);
		int gap;
		gap = burst ? 0 : $urandom_range(0, 7);
		@(negedge clk);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start          <= 1'b1;
		action         <= act;
		interval_start <= s;
		interval_end   <= e;
		do @(posedge clk); while (busy);
		runs.take_item(act, s, e);
		items_sent++;
	endtask

	// Drops start and waits until every expected run has come and the block
	// is no longer busy.
	task automatic settle();
		@(negedge clk);
		start <= 1'b0;
		while (runs.expected_runs.size() > 0 || busy)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Register writes are only issued while the block is idle.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		start     <= 1'b0;
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		runs.write_reg(idx, data);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int               len_reg;
		int               len_eff;
		int               pick;
		int               n_groups;
		int               n_adds;
		bit               big;
		logic [POS_W-1:0] s;
		logic [POS_W-1:0] e;

		clk            = 1'b0;
		arst_n         = 1'b0;
		start          = 1'b0;
		action         = ACT_ADD;
		interval_start = '0;
		interval_end   = '0;
		cfg_we         = 1'b0;
		cfg_index      = REG_TARGET_LENGTH;
		cfg_wdata      = '0;
		cycle_count    = 0;
		items_sent     = 0;
		big_phases     = 0;
		burst          = 1'b0;
		runs           = new();

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part. The first items wait out the clear pass after reset.
		// A finish with no interval since the last one reports an empty run.
		send_item(ACT_FINISH, 17'd0, 17'd0);
		// With a zero target length nothing fits, so no run qualifies.
		send_item(ACT_ADD, 17'd0, 17'd0);
		send_item(ACT_FINISH, 17'd0, 17'd0);

		// A zero minimum depth makes every position covered, but only once an
		// interval has been seen since the last finish.
		settle();
		write_reg(REG_MIN_DEPTH, 17'd0);
		send_item(ACT_ADD, 17'd0, 17'd0);
		send_item(ACT_FINISH, 17'd0, 17'd0);
		send_item(ACT_FINISH, 17'd0, 17'd0);

		// Nested intervals on a short target, then two runs of equal length
		// where the earlier one has to win.
		settle();
		write_reg(REG_TARGET_LENGTH, 17'd20);
		write_reg(REG_MIN_DEPTH, 17'd1);
		send_item(ACT_ADD, 17'd0, 17'd20);
		send_item(ACT_ADD, 17'd5, 17'd10);
		send_item(ACT_FINISH, 17'd0, 17'd0);
		send_item(ACT_ADD, 17'd2, 17'd5);
		send_item(ACT_ADD, 17'd10, 17'd13);
		send_item(ACT_FINISH, 17'd0, 17'd0);

		// An interval marked under a longer target stays in the store. After
		// the target shrinks the run is still open at the last position, and
		// the finish must clear the entry above the new length.
		settle();
		write_reg(REG_TARGET_LENGTH, 17'd1000);
		send_item(ACT_ADD, 17'd500, 17'd1000);
		settle();
		write_reg(REG_TARGET_LENGTH, 17'd600);
		send_item(ACT_FINISH, 17'd0, 17'd0);
		send_item(ACT_ADD, 17'd0, 17'd0);
		send_item(ACT_FINISH, 17'd0, 17'd0);

		// A target length above the maximum is clamped. With the largest
		// margin a full-length interval just survives trimming, one two
		// shorter does not, and out-of-range or reversed intervals are dropped.
		settle();
		write_reg(REG_TARGET_LENGTH, 17'h1FFFF);
		write_reg(REG_TRIM_MARGIN, 17'd32767);
		send_item(ACT_ADD, 17'd0, 17'd65536);
		send_item(ACT_ADD, 17'd1, 17'd65535);
		send_item(ACT_ADD, 17'd0, 17'd65537);
		send_item(ACT_ADD, 17'h1FFFF, 17'd0);
		send_item(ACT_FINISH, 17'd0, 17'd0);

		// Single positions at both ends of the full target tie on length.
		settle();
		write_reg(REG_TRIM_MARGIN, 17'd0);
		send_item(ACT_ADD, 17'd65535, 17'd65536);
		send_item(ACT_ADD, 17'd0, 17'd1);
		send_item(ACT_FINISH, 17'd0, 17'd0);

		// The highest minimum depth is never reached.
		settle();
		write_reg(REG_TARGET_LENGTH, 17'd16);
		write_reg(REG_MIN_DEPTH, 17'd65535);
		send_item(ACT_ADD, 17'd0, 17'd16);
		send_item(ACT_FINISH, 17'd0, 17'd0);

		// Random part. Each phase waits for the block to drain, picks a new
		// setting, then sends groups of intervals each closed by a finish.
		// Most targets are short so that finish walks stay cheap; at most two
		// phases use the full length, with a single group each.
		while (items_sent < ITEM_GOAL) begin
			settle();
			pick = $urandom_range(0, 99);
			big  = 1'b0;
			if (pick < 3 && big_phases < 2) begin
				big = 1'b1;
				big_phases++;
				len_reg = ($urandom_range(0, 1) == 0) ? 65536 : $urandom_range(65536, 131071);
			end else if (pick < 12) begin
				len_reg = 16;
			end else if (pick < 16) begin
				len_reg = 0;
			end else begin
				len_reg = $urandom_range(1, 300);
			end
			len_eff = (len_reg > MAX_LENGTH) ? MAX_LENGTH : len_reg;
			write_reg(REG_TARGET_LENGTH, len_reg[CFG_DATA_W-1:0]);

			pick = $urandom_range(0, 9);
			if (pick < 6)
				write_reg(REG_TRIM_MARGIN, 17'($urandom_range(0, 3)));
			else if (pick < 8)
				write_reg(REG_TRIM_MARGIN, 17'($urandom_range(4, 40)));
			else if (pick < 9)
				write_reg(REG_TRIM_MARGIN, 17'd0);
			else
				write_reg(REG_TRIM_MARGIN, 17'($urandom_range(0, 32767)));

			pick = $urandom_range(0, 9);
			if (pick < 7)
				write_reg(REG_MIN_DEPTH, 17'($urandom_range(1, 3)));
			else if (pick < 8)
				write_reg(REG_MIN_DEPTH, 17'd0);
			else if (pick < 9)
				write_reg(REG_MIN_DEPTH, 17'd65535);
			else
				write_reg(REG_MIN_DEPTH, 17'($urandom_range(0, 65535)));

			burst    = ($urandom_range(0, 3) == 0);
			n_groups = big ? 1 : $urandom_range(1, 4);
			repeat (n_groups) begin
				n_adds = $urandom_range(0, 25);
				repeat (n_adds) begin
					// Mostly intervals that fit the target; the rest is raw
					// noise over the full field width.
					if ($urandom_range(0, 9) < 8) begin
						s = 17'($urandom_range(0, len_eff));
						e = 17'($urandom_range(int'(s), len_eff));
					end else begin
						s = 17'($urandom);
						e = 17'($urandom);
					end
					send_item(ACT_ADD, s, e);
				end
				send_item(ACT_FINISH, 17'($urandom), 17'($urandom));
			end
		end

		// Let the last walk finish and leave room for any stray result.
		settle();
		repeat (16) @(posedge clk);
		if (runs.expected_runs.size() != 0) begin
			$display("%0t: %0d expected runs never arrived", $time,
				runs.expected_runs.size());
			runs.errors++;
		end
		if (runs.errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
